>>> design/mvc_pkg.sv
package mvc_pkg;

	localparam int MAX_IMAGE_WIDTH = 256;
	localparam int MAX_KERNEL_SIDE = 5;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_IMAGE_HEIGHT = 4096;

	localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
	localparam int ROW_W = $clog2(MAX_IMAGE_HEIGHT);
	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam int RS_W = $clog2(MAX_KERNEL_SIDE);
	localparam int WS_DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_CHANNELS;
	localparam int WS_AW = $clog2(WS_DEPTH);
	localparam int RB_DEPTH = MAX_KERNEL_SIDE * MAX_IMAGE_WIDTH * MAX_CHANNELS;
	localparam int RB_AW = $clog2(RB_DEPTH);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_DEPTH = 3'd4;

	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic kind;
		logic [6:0] weight_index;
		logic signed [15:0] sample_value;
	} in_word_t;

	typedef struct packed {
		logic signed [47:0] feature_value;
		logic [7:0] out_col;
		logic [11:0] out_row;
		logic frame_last;
	} out_word_t;

	typedef struct packed {
		logic [COL_W-1:0] x0;
		logic [ROW_W-1:0] y0;
		logic frame_last;
		logic [RS_W-1:0] rs0;
		logic [2:0] kw;
		logic [2:0] kh;
		logic [2:0] depth;
	} job_t;

	typedef struct packed {
		logic w_we;
		logic [WS_AW-1:0] w_addr;
		logic s_we;
		logic [RB_AW-1:0] s_addr;
		logic signed [15:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} back_stat_t;

	function automatic logic [RB_AW-1:0] rb_addr(input logic [RS_W-1:0] rs,
			input logic [COL_W-1:0] col, input logic [CH_W-1:0] ch);
		rb_addr = RB_AW'((RB_AW'(rs) * RB_AW'(MAX_IMAGE_WIDTH) + RB_AW'(col))
			* RB_AW'(MAX_CHANNELS) + RB_AW'(ch));
	endfunction

endpackage

>>> design/mvc_queue.sv
module mvc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mvc_pkg::job_t push_job,
	input logic pop,
	output mvc_pkg::job_t pop_job,
	output logic empty
);

	mvc_pkg::job_t slot_q [2];
	logic rd_q;
	logic wr_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && cnt_q != 2'd2) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			if ((push && cnt_q != 2'd2) && !(pop && !empty)) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!(push && cnt_q != 2'd2) && (pop && !empty)) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && cnt_q != 2'd2) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

>>> design/mvc_front.sv
module mvc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mvc_pkg::in_word_t in_word,
	input logic write_en,
	input logic [mvc_pkg::CFG_IDX_W-1:0] reg_index,
	input logic [mvc_pkg::CFG_DATA_W-1:0] write_data,
	input logic back_idle,
	output logic push,
	output mvc_pkg::job_t push_job,
	output mvc_pkg::mem_wr_t mem_wr
);

	logic [8:0] img_w_q;
	logic [12:0] img_h_q;
	logic [2:0] kw_q;
	logic [2:0] kh_q;
	logic [2:0] dep_q;
	logic [mvc_pkg::COL_W-1:0] col_q;
	logic [mvc_pkg::ROW_W-1:0] row_q;
	logic [mvc_pkg::CH_W-1:0] ch_q;
	logic [mvc_pkg::RS_W-1:0] rm_q;

	logic [8:0] w;
	logic [12:0] h;
	logic [2:0] kw;
	logic [2:0] kh;
	logic [2:0] dep;
	logic [8:0] col_n;
	logic [12:0] row_n;
	logic [2:0] ch_n;
	logic [3:0] rs_t;
	logic accept;
	logic emit;

	always_comb begin
		w = (img_w_q == 9'd0) ? 9'd1 :
			(img_w_q > 9'(mvc_pkg::MAX_IMAGE_WIDTH)) ? 9'(mvc_pkg::MAX_IMAGE_WIDTH) : img_w_q;
		h = (img_h_q == 13'd0) ? 13'd1 :
			(img_h_q > 13'(mvc_pkg::MAX_IMAGE_HEIGHT)) ? 13'(mvc_pkg::MAX_IMAGE_HEIGHT) : img_h_q;
		kw = (kw_q == 3'd0) ? 3'd1 :
			(kw_q > 3'(mvc_pkg::MAX_KERNEL_SIDE)) ? 3'(mvc_pkg::MAX_KERNEL_SIDE) : kw_q;
		kh = (kh_q == 3'd0) ? 3'd1 :
			(kh_q > 3'(mvc_pkg::MAX_KERNEL_SIDE)) ? 3'(mvc_pkg::MAX_KERNEL_SIDE) : kh_q;
		dep = (dep_q == 3'd0) ? 3'd1 :
			(dep_q > 3'(mvc_pkg::MAX_CHANNELS)) ? 3'(mvc_pkg::MAX_CHANNELS) : dep_q;
		col_n = {1'b0, col_q} + 9'd1;
		row_n = {1'b0, row_q} + 13'd1;
		ch_n = {1'b0, ch_q} + 3'd1;
		rs_t = 4'(rm_q) + 4'(mvc_pkg::MAX_KERNEL_SIDE) + 4'd1 - 4'(kh);
		if (rs_t >= 4'(mvc_pkg::MAX_KERNEL_SIDE)) begin
			rs_t = rs_t - 4'(mvc_pkg::MAX_KERNEL_SIDE);
		end
	end

	assign in_ready = back_idle;
	assign accept = in_valid && in_ready;
	assign emit = (ch_n == dep) && (col_n >= 9'(kw)) && (row_n >= 13'(kh));
	assign push = accept && (in_word.kind == mvc_pkg::KIND_SAMPLE) && emit;

	always_comb begin
		push_job.x0 = mvc_pkg::COL_W'(col_n - 9'(kw));
		push_job.y0 = mvc_pkg::ROW_W'(row_n - 13'(kh));
		push_job.frame_last = (col_n == w) && (row_n == h);
		push_job.rs0 = mvc_pkg::RS_W'(rs_t);
		push_job.kw = kw;
		push_job.kh = kh;
		push_job.depth = dep;
		mem_wr.data = in_word.sample_value;
		mem_wr.w_we = accept && (in_word.kind == mvc_pkg::KIND_WEIGHT)
			&& (in_word.weight_index < 7'(mvc_pkg::WS_DEPTH));
		mem_wr.w_addr = mvc_pkg::WS_AW'(in_word.weight_index);
		mem_wr.s_we = accept && (in_word.kind == mvc_pkg::KIND_SAMPLE);
		mem_wr.s_addr = mvc_pkg::rb_addr(rm_q, col_q, ch_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 9'd256;
			img_h_q <= 13'd256;
			kw_q <= 3'd3;
			kh_q <= 3'd3;
			dep_q <= 3'd1;
			col_q <= '0;
			row_q <= '0;
			ch_q <= '0;
			rm_q <= '0;
		end else if (write_en) begin
			case (reg_index)
				mvc_pkg::REG_IMAGE_WIDTH: img_w_q <= write_data[8:0];
				mvc_pkg::REG_IMAGE_HEIGHT: img_h_q <= write_data[12:0];
				mvc_pkg::REG_KERNEL_WIDTH: kw_q <= write_data[2:0];
				mvc_pkg::REG_KERNEL_HEIGHT: kh_q <= write_data[2:0];
				mvc_pkg::REG_CHANNEL_DEPTH: dep_q <= write_data[2:0];
				default: ;
			endcase
			if (reg_index <= mvc_pkg::REG_CHANNEL_DEPTH) begin
				col_q <= '0;
				row_q <= '0;
				ch_q <= '0;
				rm_q <= '0;
			end
		end else if (accept) begin
			if (in_word.kind == mvc_pkg::KIND_WEIGHT) begin
				col_q <= '0;
				row_q <= '0;
				ch_q <= '0;
				rm_q <= '0;
			end else if (ch_n < dep) begin
				ch_q <= mvc_pkg::CH_W'(ch_n);
			end else begin
				ch_q <= '0;
				if (col_n < w) begin
					col_q <= mvc_pkg::COL_W'(col_n);
				end else begin
					col_q <= '0;
					if (row_n < h) begin
						row_q <= mvc_pkg::ROW_W'(row_n);
						rm_q <= (rm_q == mvc_pkg::RS_W'(mvc_pkg::MAX_KERNEL_SIDE - 1))
							? '0 : rm_q + 1'b1;
					end else begin
						row_q <= '0;
						rm_q <= '0;
					end
				end
			end
		end
	end

endmodule

>>> design/mvc_back.sv
module mvc_back (
	input logic clk,
	input logic arst_n,
	input mvc_pkg::mem_wr_t mem_wr,
	input logic job_avail,
	input mvc_pkg::job_t job,
	output logic pop,
	output mvc_pkg::back_stat_t stat,
	output logic out_valid,
	input logic out_ready,
	output mvc_pkg::out_word_t out_word
);

	logic signed [15:0] wmem [mvc_pkg::WS_DEPTH];
	logic signed [15:0] rmem [mvc_pkg::RB_DEPTH];

	mvc_pkg::job_t job_q;
	logic busy_q;
	logic iss_q;
	logic first_q;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic [mvc_pkg::CH_W-1:0] k_q;
	logic [mvc_pkg::COL_W-1:0] cc_q;
	logic [mvc_pkg::RS_W-1:0] rs_q;
	logic [mvc_pkg::WS_AW-1:0] ws_q;

	logic valid_s1, first_s1, last_s1;
	logic signed [15:0] w_s1, s_s1;
	logic valid_s2, first_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic signed [47:0] acc_q;
	logic out_valid_q;
	mvc_pkg::out_word_t out_word_q;

	logic i_end, j_end, k_end, term_last;
	logic signed [47:0] sum;

	assign i_end = (i_q + 3'd1 == job_q.kw);
	assign j_end = (j_q + 3'd1 == job_q.kh);
	assign k_end = (3'(k_q) + 3'd1 == job_q.depth);
	assign term_last = i_end && j_end && k_end;
	assign sum = (first_s2 ? 48'sd0 : acc_q) + 48'(prod_s2);

	assign pop = job_avail && !busy_q && !out_valid_q;
	assign stat.busy = busy_q;
	assign stat.out_full = out_valid_q;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_ff @(posedge clk) begin
		if (mem_wr.w_we) begin
			wmem[mem_wr.w_addr] <= mem_wr.data;
		end
		w_s1 <= wmem[ws_q];
	end

	always_ff @(posedge clk) begin
		if (mem_wr.s_we) begin
			rmem[mem_wr.s_addr] <= mem_wr.data;
		end
		s_s1 <= rmem[mvc_pkg::rb_addr(rs_q, cc_q, k_q)];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * s_s1;
		if (pop) begin
			job_q <= job;
		end
		if (valid_s2) begin
			acc_q <= sum;
		end
		if (valid_s2 && last_s2) begin
			out_word_q.feature_value <= sum;
			out_word_q.out_col <= job_q.x0;
			out_word_q.out_row <= job_q.y0;
			out_word_q.frame_last <= job_q.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iss_q <= 1'b0;
			first_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cc_q <= '0;
			rs_q <= '0;
			ws_q <= '0;
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2 <= last_s1;
			valid_s1 <= iss_q;
			first_s1 <= first_q;
			last_s1 <= iss_q && term_last;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s2 && last_s2) begin
				busy_q <= 1'b0;
				out_valid_q <= 1'b1;
			end
			if (pop) begin
				busy_q <= 1'b1;
				iss_q <= 1'b1;
				first_q <= 1'b1;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
				cc_q <= job.x0;
				rs_q <= job.rs0;
				ws_q <= '0;
			end else if (iss_q) begin
				first_q <= 1'b0;
				ws_q <= ws_q + 1'b1;
				if (!i_end) begin
					i_q <= i_q + 3'd1;
					cc_q <= cc_q + 1'b1;
				end else begin
					i_q <= '0;
					cc_q <= job_q.x0;
					if (!j_end) begin
						j_q <= j_q + 3'd1;
						rs_q <= (rs_q == mvc_pkg::RS_W'(mvc_pkg::MAX_KERNEL_SIDE - 1))
							? '0 : rs_q + 1'b1;
					end else begin
						j_q <= '0;
						rs_q <= job_q.rs0;
						k_q <= k_q + 1'b1;
						if (k_end) begin
							iss_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !out_valid_q) else $error("result pending while job runs");
	a_s2_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> busy_q) else $error("product outside a job");
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2 && last_s2)) else $error("result without last term");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !iss_q && !valid_s1 && !valid_s2) else $error("job started while pipeline busy");

endmodule

>>> design/multichannel_valid_convolution_core.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_word (kind, weight_index, sample_value)
// out       output     out_valid / out_ready out_word (feature_value, out_col, out_row, frame_last)
// config    input      write_en              reg_index, write_data
//
// A weight or a sample that completes no window keeps in_ready high for the next item.
// A sample that completes a window queues a job whose depth*kh*kw terms go one term per cycle
// through the shared multiply-accumulate over the weight and row memories.
// in_ready stays low while a window sum is in the queue or being computed.
// A finished word waits in the output register; the next item is taken meanwhile.
// Reset clears control state only; memories hold undefined data until written.
module multichannel_valid_convolution_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mvc_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_ready,
	output mvc_pkg::out_word_t out_word,
	input logic write_en,
	input logic [mvc_pkg::CFG_IDX_W-1:0] reg_index,
	input logic [mvc_pkg::CFG_DATA_W-1:0] write_data
);

	logic push;
	logic pop;
	logic q_empty;
	mvc_pkg::job_t push_job;
	mvc_pkg::job_t pop_job;
	mvc_pkg::mem_wr_t mem_wr;
	mvc_pkg::back_stat_t stat;

	mvc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.write_en(write_en),
		.reg_index(reg_index),
		.write_data(write_data),
		.back_idle(q_empty && !stat.busy),
		.push(push),
		.push_job(push_job),
		.mem_wr(mem_wr)
	);

	mvc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.pop_job(pop_job),
		.empty(q_empty)
	);

	mvc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mem_wr(mem_wr),
		.job_avail(!q_empty),
		.job(pop_job),
		.pop(pop),
		.stat(stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

endmodule
